FILE: rtl/core/srp_pkg.sv
// Shared types, codes and helpers for the S-record line parser.
// No dependencies; srp_front, srp_fifo, srp_back and srecord_line_parser use it.
`default_nettype none

package srp_pkg;

  localparam logic [1:0] KIND_DATA   = 2'd0;
  localparam logic [1:0] KIND_ACCEPT = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_S      = 3'd1;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd2;
  localparam logic [2:0] ST_BAD_HEX   = 3'd3;
  localparam logic [2:0] ST_BAD_COUNT = 3'd4;
  localparam logic [2:0] ST_LENGTH    = 3'd5;
  localparam logic [2:0] ST_HDR_ADDR  = 3'd6;
  localparam logic [2:0] ST_CHECKSUM  = 3'd7;

  localparam logic [7:0] CHAR_S    = 8'h53;
  localparam logic [9:0] POS_MAX   = 10'd1023;
  localparam logic [7:0] SUM_OK    = 8'hFF;
  localparam logic [7:0] MIN_COUNT = 8'd3;

  typedef struct packed {
    logic       eol;
    logic       is_space;
    logic       is_s;
    logic       type_ok;
    logic       hex_ok;
    logic [3:0] nib;
  } entry_t;

  function automatic logic [2:0] addr_bytes(input logic [3:0] t);
    logic [2:0] r;
    r = 3'd2;
    case (t)
      4'd2, 4'd6, 4'd8: r = 3'd3;
      4'd3, 4'd7:       r = 3'd4;
      default:          r = 3'd2;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/core/srp_if.sv
// Valid/ready channel interfaces for the S-record line parser.
// Character input channel and result channel; no dependencies.
`default_nettype none

interface srp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       end_of_line;

  modport source (output valid, output character, output end_of_line, input ready);
  modport sink   (input valid, input character, input end_of_line, output ready);
endinterface

interface srp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [7:0]  byte_offset;
  logic [3:0]  record_type;
  logic [31:0] load_address;
  logic [2:0]  status;

  modport source (output valid, output kind, output data_byte, output byte_offset,
                  output record_type, output load_address, output status, input ready);
  modport sink   (input valid, input kind, input data_byte, input byte_offset,
                  input record_type, input load_address, input status, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/srp_front.sv
// Front end: accept characters and classify them into queue entries.
// Depends on srp_pkg and srp_in_if.
`default_nettype none

module srp_front (
  srp_in_if.sink          in_chan,
  input  wire logic       q_full,
  output logic            q_push,
  output srp_pkg::entry_t q_entry
);

  logic [7:0] c;

  assign c = in_chan.character;
  assign in_chan.ready = !q_full;
  assign q_push = in_chan.valid && !q_full;

  always_comb begin
    q_entry          = '0;
    q_entry.eol      = in_chan.end_of_line;
    q_entry.is_space = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
    q_entry.is_s     = (c == srp_pkg::CHAR_S);
    q_entry.type_ok  = (c >= 8'h30) && (c <= 8'h39) && (c != 8'h34);
    if (c >= 8'h30 && c <= 8'h39) begin
      q_entry.hex_ok = 1'b1;
      q_entry.nib    = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      q_entry.hex_ok = 1'b1;
      q_entry.nib    = c[3:0] + 4'd9;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/srp_fifo.sv
// Short queue of classified characters between front and back end.
// Depends on srp_pkg.
`default_nettype none

module srp_fifo #(
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire srp_pkg::entry_t  push_entry,
  output logic                  full,
  input  wire logic             pop,
  output logic                  q_valid,
  output srp_pkg::entry_t       q_entry
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [IW-1:0] LAST = IW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  srp_pkg::entry_t mem_r [DEPTH];
  logic [IW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full    = (count_r == FULL_CNT);
  assign q_valid = (count_r != '0);
  assign q_entry = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/srp_back.sv
// Back end: line state, field checks, data byte and verdict output register.
// Depends on srp_pkg and srp_out_if.
`default_nettype none

module srp_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  input  wire srp_pkg::entry_t q_entry,
  output logic                 q_pop,
  srp_out_if.source            out_chan
);

  logic [9:0]  pos_r, pos_nxt;
  logic [3:0]  high_r, high_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [3:0]  type_r, type_nxt;
  logic [31:0] addr_r, addr_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [7:0]  didx_r, didx_nxt;
  logic        started_r, started_nxt;
  logic        trail_r, trail_nxt;

  logic        ov_r, ov_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [7:0]  byte_r, byte_nxt;
  logic [7:0]  offs_r, offs_nxt;
  logic [3:0]  rtype_r, rtype_nxt;
  logic [31:0] laddr_r, laddr_nxt;
  logic [2:0]  stat_r, stat_nxt;

  logic [2:0]  abytes;
  logic [3:0]  need;
  logic [9:0]  pm3;
  logic [8:0]  bn;
  logic [7:0]  cur_byte;
  logic [9:0]  line_len;
  logic [2:0]  verdict;

  assign q_pop    = q_valid && (!ov_r || out_chan.ready);
  assign abytes   = srp_pkg::addr_bytes(type_r);
  assign need     = (type_r <= 4'd3) ? {1'b0, abytes} + 4'd2 : {1'b0, abytes} + 4'd1;
  assign pm3      = pos_r - 10'd3;
  assign bn       = pm3[9:1];
  assign cur_byte = {high_r, q_entry.nib};
  assign line_len = 10'd4 + {1'b0, count_r, 1'b0};

  always_comb begin
    verdict = err_r;
    if (err_r == srp_pkg::ST_OK) begin
      if (pos_r != line_len) begin
        verdict = srp_pkg::ST_LENGTH;
      end else if ((type_r <= 4'd3) ? (count_r < {4'd0, need}) : (count_r != {4'd0, need})) begin
        verdict = srp_pkg::ST_LENGTH;
      end else if (sum_r != srp_pkg::SUM_OK) begin
        verdict = srp_pkg::ST_CHECKSUM;
      end
    end
  end

  always_comb begin
    pos_nxt     = pos_r;
    high_nxt    = high_r;
    count_nxt   = count_r;
    type_nxt    = type_r;
    addr_nxt    = addr_r;
    sum_nxt     = sum_r;
    err_nxt     = err_r;
    didx_nxt    = didx_r;
    started_nxt = started_r;
    trail_nxt   = trail_r;
    ov_nxt      = ov_r && !out_chan.ready;
    kind_nxt    = kind_r;
    byte_nxt    = byte_r;
    offs_nxt    = offs_r;
    rtype_nxt   = rtype_r;
    laddr_nxt   = laddr_r;
    stat_nxt    = stat_r;
    if (q_pop) begin
      if (q_entry.eol) begin
        if (started_r) begin
          ov_nxt    = 1'b1;
          kind_nxt  = (verdict == srp_pkg::ST_OK) ? srp_pkg::KIND_ACCEPT
                                                  : srp_pkg::KIND_REJECT;
          byte_nxt  = 8'd0;
          offs_nxt  = didx_r;
          rtype_nxt = type_r;
          laddr_nxt = addr_r;
          stat_nxt  = verdict;
        end
        pos_nxt     = '0;
        high_nxt    = '0;
        count_nxt   = '0;
        type_nxt    = '0;
        addr_nxt    = '0;
        sum_nxt     = '0;
        err_nxt     = srp_pkg::ST_OK;
        didx_nxt    = '0;
        started_nxt = 1'b0;
        trail_nxt   = 1'b0;
      end else if (q_entry.is_space) begin
        if (started_r) begin
          trail_nxt = 1'b1;
        end
      end else begin
        started_nxt = 1'b1;
        if (trail_r) begin
          if (err_nxt == srp_pkg::ST_OK) begin
            err_nxt = (pos_r == 10'd1) ? srp_pkg::ST_BAD_TYPE : srp_pkg::ST_BAD_HEX;
          end
          trail_nxt = 1'b0;
        end
        if (pos_r != srp_pkg::POS_MAX) begin
          pos_nxt = pos_r + 10'd1;
        end
        if (pos_r == 10'd0) begin
          if (!q_entry.is_s && err_nxt == srp_pkg::ST_OK) begin
            err_nxt = srp_pkg::ST_NO_S;
          end
        end else if (pos_r == 10'd1) begin
          if (q_entry.type_ok) begin
            type_nxt = q_entry.nib;
          end else if (err_nxt == srp_pkg::ST_OK) begin
            err_nxt = srp_pkg::ST_BAD_TYPE;
          end
        end else if (!q_entry.hex_ok) begin
          if (err_nxt == srp_pkg::ST_OK) begin
            err_nxt = srp_pkg::ST_BAD_HEX;
          end
        end else if (!pos_r[0]) begin
          high_nxt = q_entry.nib;
        end else begin
          sum_nxt = sum_r + cur_byte;
          if (bn == 9'd0) begin
            count_nxt = cur_byte;
            if (cur_byte < srp_pkg::MIN_COUNT && err_nxt == srp_pkg::ST_OK) begin
              err_nxt = srp_pkg::ST_BAD_COUNT;
            end
          end else if (bn <= {6'd0, abytes}) begin
            addr_nxt = {addr_r[23:0], cur_byte};
            if (bn == {6'd0, abytes} && type_r == 4'd0 && addr_nxt != '0
                && err_nxt == srp_pkg::ST_OK) begin
              err_nxt = srp_pkg::ST_HDR_ADDR;
            end
          end else if (type_r <= 4'd3 && bn < {1'b0, count_r}
                       && err_nxt == srp_pkg::ST_OK) begin
            ov_nxt    = 1'b1;
            kind_nxt  = srp_pkg::KIND_DATA;
            byte_nxt  = cur_byte;
            offs_nxt  = didx_r;
            rtype_nxt = type_r;
            laddr_nxt = addr_r;
            stat_nxt  = srp_pkg::ST_OK;
            didx_nxt  = didx_r + 8'd1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      high_r    <= '0;
      count_r   <= '0;
      type_r    <= '0;
      addr_r    <= '0;
      sum_r     <= '0;
      err_r     <= srp_pkg::ST_OK;
      didx_r    <= '0;
      started_r <= 1'b0;
      trail_r   <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      pos_r     <= pos_nxt;
      high_r    <= high_nxt;
      count_r   <= count_nxt;
      type_r    <= type_nxt;
      addr_r    <= addr_nxt;
      sum_r     <= sum_nxt;
      err_r     <= err_nxt;
      didx_r    <= didx_nxt;
      started_r <= started_nxt;
      trail_r   <= trail_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    byte_r  <= byte_nxt;
    offs_r  <= offs_nxt;
    rtype_r <= rtype_nxt;
    laddr_r <= laddr_nxt;
    stat_r  <= stat_nxt;
  end

  assign out_chan.valid        = ov_r;
  assign out_chan.kind         = kind_r;
  assign out_chan.data_byte    = byte_r;
  assign out_chan.byte_offset  = offs_r;
  assign out_chan.record_type  = rtype_r;
  assign out_chan.load_address = laddr_r;
  assign out_chan.status       = stat_r;

endmodule

`default_nettype wire

FILE: rtl/core/srecord_line_parser.sv
// S-record line parser: one ASCII character per transaction in, data bytes
// and a per-line verdict out. Depends on srp_pkg, srp_if, srp_front,
// srp_fifo and srp_back.
//
// in_chan carries one character per transaction; end_of_line marks the
// transaction that closes a line (its character is ignored). out_chan
// carries a tentative data byte (kind data) for every data byte of a record
// of type 0 to 3 while the line is still clean, and one verdict (accepted
// or rejected with status) per nonblank line. Blank lines give nothing.
// Throughput is one character per cycle. A character is classified on entry
// and written into a QUEUE_DEPTH-entry queue; the back end takes one entry
// per cycle and registers any result, which passes the queue entry and then
// the result register before it is visible. When the receiver stalls, the
// result register holds, the back end stops taking entries, and
// in_chan.ready drops once the queue is full. Reset empties the queue,
// clears the line state and drops out_chan.valid; no warm-up is needed.
`default_nettype none

module srecord_line_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  srp_in_if.sink     in_chan,
  srp_out_if.source  out_chan
);

  logic            push, full, pop, q_valid;
  srp_pkg::entry_t push_entry, q_entry;

  srp_front u_front (
    .in_chan (in_chan),
    .q_full  (full),
    .q_push  (push),
    .q_entry (push_entry)
  );

  srp_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .q_valid    (q_valid),
    .q_entry    (q_entry)
  );

  srp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_entry  (q_entry),
    .q_pop    (pop),
    .out_chan (out_chan)
  );

`ifndef NO_ASSERTIONS
  a_data_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.kind == srp_pkg::KIND_DATA |-> out_chan.status == srp_pkg::ST_OK)
    else $error("data byte carries a nonzero status");

  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.kind != srp_pkg::KIND_DATA
    |-> ((out_chan.kind == srp_pkg::KIND_ACCEPT) == (out_chan.status == srp_pkg::ST_OK)))
    else $error("verdict kind disagrees with status");

  a_full_queue: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> q_valid)
    else $error("input stalled with an empty queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("queue popped while empty");
`endif

endmodule

`default_nettype wire
